>>> hdl/alss_pkg.sv
// Shared types and constants for the actuator limit-switch supervisor.
package alss_pkg;

  localparam int unsigned TICKS_PER_SECOND = 18;
  localparam int unsigned GRACE_SECONDS    = 7;

  localparam int unsigned CNT_W   = 5;
  localparam int unsigned WD_W    = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [WD_W-1:0] WD_MAX = '1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MAX     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_UNIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_CODE  = 3'd5;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] COUNT_MAX_RST     = 5'd18;
  localparam logic [CNT_W-1:0] ON_THRESHOLD_RST  = 5'd12;
  localparam logic [CNT_W-1:0] OFF_THRESHOLD_RST = 5'd2;

  typedef struct packed {
    logic switch_level;
    logic command_set;
    logic inhibit;
  } in_word_t;

  typedef struct packed {
    logic             command_out;
    logic             stable_on;
    logic             fault_flag;
    logic             alarm_pulse;
    logic [7:0]       alarm_unit_out;
    logic [15:0]      message_out;
    logic [CNT_W-1:0] debounce_count;
    logic [WD_W-1:0]  watch_count;
  } out_word_t;

endpackage

>>> hdl/actuator_limit_switch_supervisor.sv
// Top level of the actuator limit-switch supervisor: debounce, watchdog and alarm.
// Each accepted word's result is registered in out_r, or in skid_r while out_r is held.
// Throughput: one word per cycle while in_stall is low.
// A two-entry output stage (result register plus skid register) lets input flow on
// while one result waits; in_stall rises only when the skid register is full.
// Reset (synchronous, rst_n low): counters and flags clear, config returns to defaults.
module actuator_limit_switch_supervisor
  import alss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CNT_W-1:0] count_max_r, on_thresh_r, off_thresh_r;
  logic [7:0]       timeout_r, alarm_unit_r;
  logic [15:0]      message_code_r;

  logic [CNT_W-1:0] sw_cnt_r, sw_cnt_nxt;
  logic             stable_r, stable_nxt;
  logic             cmd_r, cmd_nxt;
  logic [WD_W-1:0]  wd_cnt_r, wd_cnt_nxt;
  logic             fault_r, fault_nxt;
  logic             alarm;

  logic [31:0]      lim_full;
  logic [WD_W-1:0]  wd_limit;

  out_word_t        res;
  out_word_t        out_r, skid_r;
  logic             out_v_r, skid_v_r;
  logic             take_in, out_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_v_r;
  assign out_valid = out_v_r;
  assign out_word  = out_r;
  assign take_in   = in_valid & ~skid_v_r;
  assign out_fire  = out_v_r & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_max_r    <= COUNT_MAX_RST;
      on_thresh_r    <= ON_THRESHOLD_RST;
      off_thresh_r   <= OFF_THRESHOLD_RST;
      timeout_r      <= '0;
      alarm_unit_r   <= '0;
      message_code_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COUNT_MAX:     count_max_r    <= cfg_data[CNT_W-1:0];
        CFG_ON_THRESHOLD:  on_thresh_r    <= cfg_data[CNT_W-1:0];
        CFG_OFF_THRESHOLD: off_thresh_r   <= cfg_data[CNT_W-1:0];
        CFG_TIMEOUT:       timeout_r      <= cfg_data[7:0];
        CFG_ALARM_UNIT:    alarm_unit_r   <= cfg_data[7:0];
        CFG_MESSAGE_CODE:  message_code_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Watchdog limit, saturated to the counter range
  assign lim_full = (32'(timeout_r) + 32'(GRACE_SECONDS)) * 32'(TICKS_PER_SECOND);
  assign wd_limit = (lim_full > 32'(WD_MAX)) ? WD_MAX : lim_full[WD_W-1:0];

  always_comb begin
    sw_cnt_nxt = sw_cnt_r;
    stable_nxt = stable_r;
    cmd_nxt    = cmd_r | in_word.command_set;
    wd_cnt_nxt = wd_cnt_r;
    fault_nxt  = fault_r;
    alarm      = 1'b0;

    if (in_word.switch_level) begin
      if (sw_cnt_r < count_max_r) sw_cnt_nxt = sw_cnt_r + 1'b1;
    end else begin
      if (sw_cnt_r != '0) sw_cnt_nxt = sw_cnt_r - 1'b1;
      if (cmd_nxt) begin
        if (wd_cnt_r < wd_limit) begin
          wd_cnt_nxt = wd_cnt_r + 1'b1;
        end else if (!fault_r) begin
          fault_nxt  = 1'b1;
          wd_cnt_nxt = '0;
          alarm      = 1'b1;
        end
      end else begin
        if (wd_cnt_r != '0) wd_cnt_nxt = wd_cnt_r - 1'b1;
        fault_nxt = 1'b0;
      end
    end

    // Confirmed switch sets stable, drops the command and clears the watchdog and fault
    if (sw_cnt_nxt > on_thresh_r) begin
      stable_nxt = 1'b1;
      wd_cnt_nxt = '0;
      fault_nxt  = 1'b0;
      cmd_nxt    = 1'b0;
    end
    if (sw_cnt_nxt < off_thresh_r) stable_nxt = 1'b0;
    if (in_word.inhibit) cmd_nxt = 1'b0;

    res.command_out    = cmd_nxt;
    res.stable_on      = stable_nxt;
    res.fault_flag     = fault_nxt;
    res.alarm_pulse    = alarm;
    res.alarm_unit_out = alarm ? alarm_unit_r : 8'd0;
    res.message_out    = alarm ? message_code_r : 16'd0;
    res.debounce_count = sw_cnt_nxt;
    res.watch_count    = wd_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_cnt_r <= '0;
      stable_r <= 1'b0;
      cmd_r    <= 1'b0;
      wd_cnt_r <= '0;
      fault_r  <= 1'b0;
    end else if (take_in) begin
      sw_cnt_r <= sw_cnt_nxt;
      stable_r <= stable_nxt;
      cmd_r    <= cmd_nxt;
      wd_cnt_r <= wd_cnt_nxt;
      fault_r  <= fault_nxt;
    end
  end

  // Output register with skid: park the new word when the result register is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take_in) begin
      if (out_v_r && out_stall) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      if (out_v_r && out_stall) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end else if (out_fire && skid_v_r) begin
      out_r <= skid_r;
    end
  end

endmodule

>>> hdl/alss_checker.sv
// Port-level checks for the actuator limit-switch supervisor, bound to the top level.
module alss_checker
  import alss_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // Alarm payload appears only with the alarm pulse
  a_alarm_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.alarm_pulse) |->
      (out_word.alarm_unit_out == 8'd0 && out_word.message_out == 16'd0))
    else $error("alarm payload without alarm pulse");

  // Raising the alarm restarts the watchdog
  a_alarm_wd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.alarm_pulse) |-> (out_word.watch_count == '0))
    else $error("watchdog not cleared on alarm");

  // Input side stalls only while a result is waiting
  a_stall_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // Held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result word changed");

endmodule

bind actuator_limit_switch_supervisor alss_checker u_alss_checker (.*);

>>> tb/tb_actuator_limit_switch_supervisor.sv
// Self-checking testbench for the actuator limit-switch supervisor with random stalls and gaps.
`timescale 1ns / 100ps

class limit_watch_model;
  logic [4:0]  count_max;
  logic [4:0]  on_thr;
  logic [4:0]  off_thr;
  logic [7:0]  timeout_s;
  logic [7:0]  unit;
  logic [15:0] msg_code;

  logic [4:0]  sw_count;
  logic        stable;
  logic        command;
  logic [12:0] watchdog;
  logic        fault;

  alss_pkg::out_word_t expected_status[$];
  int unsigned mismatch_count;

  function new();
    count_max = alss_pkg::COUNT_MAX_RST;
    on_thr = alss_pkg::ON_THRESHOLD_RST;
    off_thr = alss_pkg::OFF_THRESHOLD_RST;
    timeout_s = '0;
    unit = '0;
    msg_code = '0;
    sw_count = '0;
    stable = 1'b0;
    command = 1'b0;
    watchdog = '0;
    fault = 1'b0;
    mismatch_count = 0;
  endfunction

  function void set_register(logic [alss_pkg::CFG_IDX_W-1:0] idx,
                             logic [alss_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      alss_pkg::CFG_COUNT_MAX:     count_max = data[4:0];
      alss_pkg::CFG_ON_THRESHOLD:  on_thr = data[4:0];
      alss_pkg::CFG_OFF_THRESHOLD: off_thr = data[4:0];
      alss_pkg::CFG_TIMEOUT:       timeout_s = data[7:0];
      alss_pkg::CFG_ALARM_UNIT:    unit = data[7:0];
      alss_pkg::CFG_MESSAGE_CODE:  msg_code = data;
      default: ;
    endcase
  endfunction

  function int unsigned watch_limit();
    int unsigned lim;
    lim = (timeout_s + alss_pkg::GRACE_SECONDS) * alss_pkg::TICKS_PER_SECOND;
    if (lim > alss_pkg::WD_MAX) lim = alss_pkg::WD_MAX;
    return lim;
  endfunction

  // Advance one tick and queue the status word it produces.
  function void take_tick(alss_pkg::in_word_t w);
    alss_pkg::out_word_t want;
    logic alarm;
    int unsigned lim;
    alarm = 1'b0;
    lim = watch_limit();
    if (w.command_set) command = 1'b1;
    if (w.switch_level) begin
      if (sw_count < count_max) sw_count = sw_count + 1'b1;
    end else begin
      if (sw_count != 0) sw_count = sw_count - 1'b1;
      if (command) begin
        if (watchdog < lim) begin
          watchdog = watchdog + 1'b1;
        end else if (!fault) begin
          fault = 1'b1;
          watchdog = '0;
          alarm = 1'b1;
        end
      end else begin
        if (watchdog != 0) watchdog = watchdog - 1'b1;
        fault = 1'b0;
      end
    end
    // a confirmed switch ends the travel
    if (sw_count > on_thr) begin
      stable = 1'b1;
      watchdog = '0;
      fault = 1'b0;
      command = 1'b0;
    end
    if (sw_count < off_thr) stable = 1'b0;
    if (w.inhibit) command = 1'b0;

    want.command_out = command;
    want.stable_on = stable;
    want.fault_flag = fault;
    want.alarm_pulse = alarm;
    want.alarm_unit_out = alarm ? unit : 8'h00;
    want.message_out = alarm ? msg_code : 16'h0000;
    want.debounce_count = sw_count;
    want.watch_count = watchdog;
    expected_status.push_back(want);
  endfunction

  function void flag(string what, logic [15:0] want_v, logic [15:0] got_v);
    if (mismatch_count < 200)
      $display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
    mismatch_count++;
  endfunction

  function void check_status(alss_pkg::out_word_t got);
    alss_pkg::out_word_t want;
    if (expected_status.size() == 0) begin
      if (mismatch_count < 200)
        $display("%0t: status word expected none got %h", $time, got);
      mismatch_count++;
      return;
    end
    want = expected_status.pop_front();
    if (got.command_out !== want.command_out)
      flag("command_out", want.command_out, got.command_out);
    if (got.stable_on !== want.stable_on)
      flag("stable_on", want.stable_on, got.stable_on);
    if (got.fault_flag !== want.fault_flag)
      flag("fault_flag", want.fault_flag, got.fault_flag);
    if (got.alarm_pulse !== want.alarm_pulse)
      flag("alarm_pulse", want.alarm_pulse, got.alarm_pulse);
    if (got.alarm_unit_out !== want.alarm_unit_out)
      flag("alarm_unit_out", want.alarm_unit_out, got.alarm_unit_out);
    if (got.message_out !== want.message_out)
      flag("message_out", want.message_out, got.message_out);
    if (got.debounce_count !== want.debounce_count)
      flag("debounce_count", want.debounce_count, got.debounce_count);
    if (got.watch_count !== want.watch_count)
      flag("watch_count", want.watch_count, got.watch_count);
  endfunction

  function int unsigned pending();
    return expected_status.size();
  endfunction
endclass

module tb_actuator_limit_switch_supervisor
  import alss_pkg::*;
();

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  limit_watch_model sb;
  int unsigned tx_pct = 0;
  int unsigned rx_pct = 0;
  int unsigned ticks_sent = 0;

  actuator_limit_switch_supervisor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.take_tick(in_word);
    if (rst_n && out_valid && !out_stall) sb.check_status(out_word);
  end

  task automatic send_tick(input logic sw, input logic set, input logic inh);
    in_word_t w;
    w.switch_level = sw;
    w.command_set = set;
    w.inhibit = inh;
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
    if (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_pct);
    end
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic write_regs(input logic [4:0] cmax, input logic [4:0] on_t,
                            input logic [4:0] off_t, input logic [7:0] tmo,
                            input logic [7:0] unit, input logic [15:0] msg);
    put_reg(CFG_COUNT_MAX, {11'd0, cmax});
    put_reg(CFG_ON_THRESHOLD, {11'd0, on_t});
    put_reg(CFG_OFF_THRESHOLD, {11'd0, off_t});
    put_reg(CFG_TIMEOUT, {8'd0, tmo});
    put_reg(CFG_ALARM_UNIT, {8'd0, unit});
    put_reg(CFG_MESSAGE_CODE, msg);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait until every status word is back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_sequence();
    int unsigned lim;
    int unsigned n;
    int unsigned r;
    lim = sb.watch_limit();
    r = $urandom_range(99);
    if (r < 65) begin
      // travel: command, switch off for a while, then the switch closes
      send_tick(1'b0, 1'b1, 1'b0);
      if ($urandom_range(3) == 0 && lim < 300) n = lim + $urandom_range(lim + 20);
      else n = $urandom_range(20);
      repeat (n) send_tick($urandom_range(15) == 0, $urandom_range(7) == 0, 1'b0);
      n = $urandom_range(sb.count_max + 3);
      repeat (n) send_tick(1'b1, $urandom_range(1) == 1, $urandom_range(9) == 0);
      n = $urandom_range(10);
      repeat (n) send_tick(1'b0, 1'b0, $urandom_range(1) == 1);
    end else if (r < 85) begin
      // travel cut short by inhibit, then let the watchdog run down
      send_tick(1'b0, 1'b1, 1'b0);
      n = $urandom_range(30);
      repeat (n) send_tick(1'b0, 1'b0, 1'b0);
      send_tick($urandom_range(1) == 1, 1'b0, 1'b1);
      n = $urandom_range(12);
      repeat (n) send_tick(1'b0, 1'b0, 1'b0);
    end else begin
      n = $urandom_range(15, 1);
      repeat (n) begin
        r = $urandom_range(7);
        send_tick(r[2], r[1], r[0]);
      end
    end
  endtask

  task automatic run_phase(input int unsigned tx, input int unsigned rx,
                           input int unsigned quota);
    tx_pct = tx;
    rx_pct = rx;
    ticks_sent = 0;
    while (ticks_sent < quota) run_sequence();
  endtask

  initial begin
    sb = new();
    tx_pct = 16;
    rx_pct = 47;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_regs(5'd4, 5'd2, 5'd1, 8'd0, 8'h5A, 16'hA5C3);
    for (int i = 0; i < 8; i++) send_tick(i[2], i[1], i[0]);
    repeat (4) send_tick(1'b1, 1'b0, 1'b0);
    // count left above a lowered maximum
    settle();
    put_reg(CFG_COUNT_MAX, 16'd2);
    cfg_valid <= 1'b0;
    repeat (2) send_tick(1'b1, 1'b1, 1'b0);
    repeat (2) send_tick(1'b0, 1'b0, 1'b0);
    // zero maximum: the count never rises
    settle();
    put_reg(CFG_COUNT_MAX, 16'd0);
    cfg_valid <= 1'b0;
    repeat (3) send_tick(1'b1, 1'b1, 1'b0);
    repeat (3) send_tick(1'b0, 1'b1, 1'b0);

    settle();
    write_regs(5'd31, 5'd30, 5'd0, 8'd0, 8'hFF, 16'hFFFF);
    run_phase(16, 47, 220);

    settle();
    write_regs(5'd18, 5'd12, 5'd2, 8'd1, 8'($urandom), 16'($urandom));
    run_phase(47, 16, 220);

    settle();
    write_regs(5'($urandom_range(31, 1)), 5'd0, 5'($urandom_range(31)), 8'd0, 8'h00, 16'h0000);
    run_phase(0, 0, 170);

    settle();
    write_regs(5'd31, 5'd31, 5'd31, 8'd255, 8'($urandom), 16'($urandom));
    run_phase(0, 0, 40);

    settle();
    if (sb.mismatch_count == 0) begin
      $display("actuator_limit_switch_supervisor test passed");
    end else begin
      $display("actuator_limit_switch_supervisor test failed");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("actuator_limit_switch_supervisor test failed");
    $finish;
  end

endmodule

>>> actuator_limit_switch_supervisor.f
hdl/alss_pkg.sv
hdl/actuator_limit_switch_supervisor.sv
hdl/alss_checker.sv
tb/tb_actuator_limit_switch_supervisor.sv
